@@ src/mrs_pkg.sv @@
// Shared types, constants and the CRC helper for the Modbus RTU register slave.
package mrs_pkg;

    localparam int REG_COUNT   = 14;
    localparam int FRAME_BYTES = 16;

    localparam int REG_IDX_W = $clog2(REG_COUNT);
    localparam int FIDX_W    = $clog2(FRAME_BYTES);
    localparam int FCNT_W    = $clog2(FRAME_BYTES + 1);

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam int REPLY_MAX   = 33;
    localparam int TX_CNT_W    = $clog2(REPLY_MAX + 1);
    localparam int READ_FIXED  = 5;
    localparam int ECHO_BYTES  = 8;

    localparam int MIN_FRAME        = 8;
    localparam int MIN_MULTI_FRAME  = 15;
    localparam int CRC_MARK_SHORT   = 6;
    localparam int CRC_MARK_LONG    = 13;
    localparam int READ_START_LIMIT = 7;
    localparam int READ_END_LIMIT   = 15;
    localparam int WRITE_ONE_LIMIT  = 5;

    localparam logic [15:0] CRC_POLY = 16'hA001;
    localparam logic [15:0] CRC_INIT = 16'hFFFF;

    localparam logic [7:0] FC_READ_HOLD      = 8'h03;
    localparam logic [7:0] FC_WRITE_ONE      = 8'h06;
    localparam logic [7:0] FC_WRITE_MULTI    = 8'h10;
    localparam logic [7:0] WRITE_MULTI_BYTES = 8'h06;
    localparam logic [7:0] GROUP_BASE        = 8'd100;
    localparam logic [7:0] BROADCAST_ADDR    = 8'h00;
    localparam logic [7:0] ADDR_RESET        = 8'h01;

    typedef enum logic [1:0] {
        CMD_LOCAL,
        CMD_READ,
        CMD_WRITE_ONE,
        CMD_WRITE_MULTI
    } cmd_kind_t;

    // pb holds frame bytes 2 through 12
    typedef struct packed {
        cmd_kind_t        kind;
        logic             own;
        logic [2:0]       start;
        logic [3:0]       qty;
        logic [3:0]       lidx;
        logic [15:0]      lval;
        logic [10:0][7:0] pb;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

    typedef enum logic {
        BK_IDLE,
        BK_EMIT
    } back_state_t;

    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] v);
        logic [15:0] c;
        c = crc_in ^ {8'h00, v};
        for (int k = 0; k < 8; k++)
        begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

@@ src/modbus_rtu_register_slave_core.sv @@
// Top level of the Modbus RTU holding-register slave: address register, front, queue, back.
//
// A frame byte or a local register update is taken while busy is low. After the last byte of a
// frame, the front end checks address, function, CRC and limits and queues a command, with busy
// high. A two-entry command queue separates the front end from the back end, so bytes of the
// next frame keep flowing while a reply goes out. The back end picks up a command from the queue
// and applies register writes, then, after one output register stage, streams the reply one
// byte per clock with tx_strobe high (8 bytes for writes, 5 plus twice the register count for
// reads). Read and multi-write replies get a CRC computed byte by byte as they go out; a
// single-register write echoes the CRC bytes of its frame. busy also stays high while the
// queue is full. tx_strobe marks each reply byte for exactly one cycle and cannot be held off.
// Invalid or short frames produce no reply.
module modbus_rtu_register_slave_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        func,
    input  logic [7:0]  rx_byte,
    input  logic        frame_end,
    input  logic [3:0]  local_index,
    input  logic [15:0] local_value,
    output logic [7:0]  tx_byte,
    output logic        tx_last,
    output logic        tx_strobe,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_data
);
    import mrs_pkg::*;

    logic [7:0]    addr_reg, addr_next;
    logic          q_push, q_pop;
    cmd_t          push_cmd, head;
    queue_status_t q_stat;

    assign cfg_ready = 1'b1;
    assign addr_next = (cfg_valid && cfg_ready) ? cfg_data : addr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            addr_reg <= ADDR_RESET;
        end
        else
        begin
            addr_reg <= addr_next;
        end
    end

    mrs_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .func          (func),
        .rx_byte       (rx_byte),
        .frame_end     (frame_end),
        .local_index   (local_index),
        .local_value   (local_value),
        .slave_address (addr_reg),
        .q_stat        (q_stat),
        .busy          (busy),
        .push          (q_push),
        .push_cmd      (push_cmd)
    );

    mrs_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_cmd (push_cmd),
        .pop      (q_pop),
        .head     (head),
        .q_stat   (q_stat)
    );

    mrs_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .slave_address (addr_reg),
        .head          (head),
        .q_stat        (q_stat),
        .pop           (q_pop),
        .tx_byte       (tx_byte),
        .tx_last       (tx_last),
        .tx_strobe     (tx_strobe)
    );

`ifndef ASSERT_OFF
    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_stat.full)
        else $error("command pushed into a full queue");

    a_frame_close_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && !func && frame_end) |=> busy)
        else $error("front end accepted an item during frame classification");

    a_reply_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
        (tx_strobe && !tx_last) |=> tx_strobe)
        else $error("reply stream broke before its last byte");

    a_reply_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (tx_strobe && tx_last) |=> !tx_strobe)
        else $error("reply byte right after the last byte of a reply");
`endif

endmodule

@@ src/mrs_front.sv @@
// Front end: collects frame bytes, runs the CRC, classifies finished frames into commands.
module mrs_front (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic                  func,
    input  logic [7:0]            rx_byte,
    input  logic                  frame_end,
    input  logic [3:0]            local_index,
    input  logic [15:0]           local_value,
    input  logic [7:0]            slave_address,
    input  mrs_pkg::queue_status_t q_stat,
    output logic                  busy,
    output logic                  push,
    output mrs_pkg::cmd_t         push_cmd
);
    import mrs_pkg::*;

    logic [7:0]        store_reg [FRAME_BYTES];
    logic [FCNT_W-1:0] count_reg, count_next;
    logic [15:0]       crc_reg, crc_next;
    logic [15:0]       crc6_reg, crc6_next;
    logic [15:0]       crc13_reg, crc13_next;
    logic              fin_reg, fin_next;

    logic              accept;
    logic              store_we;
    logic [FCNT_W-1:0] count_inc;
    logic [15:0]       crc_upd;

    logic [15:0] start16, qty16, rx6, rx13;
    logic [16:0] span;
    logic [7:0]  group_addr;
    logic        own, wr_ok, crc6_ok, crc13_ok, long_enough, multi_len;
    logic        fin_push;
    cmd_kind_t   fin_kind;

    assign busy      = fin_reg | q_stat.full;
    assign accept    = start & ~busy;
    assign store_we  = accept & ~func & (count_reg < FCNT_W'(FRAME_BYTES));
    assign count_inc = count_reg + FCNT_W'(1);
    assign crc_upd   = crc_byte(crc_reg, rx_byte);

    always_ff @(posedge clk)
    begin
        if (store_we)
        begin
            store_reg[count_reg[FIDX_W-1:0]] <= rx_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            crc_reg   <= CRC_INIT;
            crc6_reg  <= '0;
            crc13_reg <= '0;
            fin_reg   <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            crc_reg   <= crc_next;
            crc6_reg  <= crc6_next;
            crc13_reg <= crc13_next;
            fin_reg   <= fin_next;
        end
    end

    always_comb
    begin
        count_next = count_reg;
        crc_next   = crc_reg;
        crc6_next  = crc6_reg;
        crc13_next = crc13_reg;
        fin_next   = fin_reg;
        if (fin_reg)
        begin
            // frame classified this cycle: rearm for the next one
            count_next = '0;
            crc_next   = CRC_INIT;
            fin_next   = 1'b0;
        end
        else if (accept && !func)
        begin
            if (store_we)
            begin
                count_next = count_inc;
                crc_next   = crc_upd;
                if (count_inc == FCNT_W'(CRC_MARK_SHORT))
                begin
                    crc6_next = crc_upd;
                end
                if (count_inc == FCNT_W'(CRC_MARK_LONG))
                begin
                    crc13_next = crc_upd;
                end
            end
            fin_next = frame_end;
        end
    end

    assign start16 = {store_reg[2], store_reg[3]};
    assign qty16   = {store_reg[4], store_reg[5]};
    assign rx6     = {store_reg[6], store_reg[7]};
    assign rx13    = {store_reg[13], store_reg[14]};
    assign span    = {1'b0, start16} + {1'b0, qty16};

    assign group_addr  = (slave_address == BROADCAST_ADDR) ? GROUP_BASE
                       : ((slave_address - 8'd1) >> 2) + GROUP_BASE;
    assign own         = (store_reg[0] == slave_address);
    assign wr_ok       = own | (store_reg[0] == BROADCAST_ADDR) | (store_reg[0] == group_addr);
    assign crc6_ok     = (rx6 == crc6_reg) | (rx6 == 16'h0000);
    assign crc13_ok    = (rx13 == crc13_reg) | (rx13 == 16'h0000);
    assign long_enough = (count_reg >= FCNT_W'(MIN_FRAME));
    assign multi_len   = (count_reg >= FCNT_W'(MIN_MULTI_FRAME));

    always_comb
    begin
        fin_push = 1'b0;
        fin_kind = CMD_READ;
        if (long_enough)
        begin
            unique case (store_reg[1])
                FC_READ_HOLD:
                begin
                    fin_kind = CMD_READ;
                    fin_push = own & crc6_ok & (start16 < 16'(READ_START_LIMIT))
                             & (span < 17'(READ_END_LIMIT));
                end
                FC_WRITE_ONE:
                begin
                    fin_kind = CMD_WRITE_ONE;
                    fin_push = wr_ok & crc6_ok & (start16 < 16'(WRITE_ONE_LIMIT));
                end
                FC_WRITE_MULTI:
                begin
                    fin_kind = CMD_WRITE_MULTI;
                    fin_push = multi_len & wr_ok & (store_reg[6] == WRITE_MULTI_BYTES)
                             & (start16 == 16'h0000) & crc13_ok;
                end
                default:
                begin
                    fin_push = 1'b0;
                end
            endcase
        end
    end

    assign push = (accept & func) | (fin_reg & fin_push);

    always_comb
    begin
        push_cmd.kind  = (accept && func) ? CMD_LOCAL : fin_kind;
        push_cmd.own   = own;
        push_cmd.start = start16[2:0];
        push_cmd.qty   = qty16[3:0];
        push_cmd.lidx  = local_index;
        push_cmd.lval  = local_value;
        for (int i = 0; i < 11; i++)
        begin
            push_cmd.pb[i] = store_reg[i + 2];
        end
    end

endmodule

@@ src/mrs_queue.sv @@
// Command queue between the frame front end and the register back end.
module mrs_queue (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  mrs_pkg::cmd_t          push_cmd,
    input  logic                   pop,
    output mrs_pkg::cmd_t          head,
    output mrs_pkg::queue_status_t q_stat
);
    import mrs_pkg::*;

    cmd_t              entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wptr_reg, wptr_next;
    logic [QPTR_W-1:0] rptr_reg, rptr_next;
    logic [QCNT_W-1:0] cnt_reg, cnt_next;

    function automatic logic [QPTR_W-1:0] ptr_adv(input logic [QPTR_W-1:0] p);
        return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + QPTR_W'(1);
    endfunction

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_comb
    begin
        wptr_next = push ? ptr_adv(wptr_reg) : wptr_reg;
        rptr_next = pop ? ptr_adv(rptr_reg) : rptr_reg;
        unique case ({push, pop})
            2'b10:   cnt_next = cnt_reg + QCNT_W'(1);
            2'b01:   cnt_next = cnt_reg - QCNT_W'(1);
            default: cnt_next = cnt_reg;
        endcase
    end

    assign head         = entry_reg[rptr_reg];
    assign q_stat.full  = (cnt_reg == QCNT_W'(QUEUE_DEPTH));
    assign q_stat.empty = (cnt_reg == '0);

endmodule

@@ src/mrs_back.sv @@
// Back end: holding register file, command execution and reply byte streaming with CRC.
module mrs_back (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic [7:0]             slave_address,
    input  mrs_pkg::cmd_t          head,
    input  mrs_pkg::queue_status_t q_stat,
    output logic                   pop,
    output logic [7:0]             tx_byte,
    output logic                   tx_last,
    output logic                   tx_strobe
);
    import mrs_pkg::*;

    back_state_t         state_reg, state_next;
    cmd_t                cmd_reg, cmd_next;
    logic [TX_CNT_W-1:0] k_reg, k_next;
    logic [TX_CNT_W-1:0] len_reg, len_next;
    logic [15:0]         crc_reg, crc_next;
    logic [15:0]         hold_reg [REG_COUNT];
    logic [15:0]         hold_next [REG_COUNT];
    logic [7:0]          tx_byte_reg, tx_byte_next;
    logic                tx_last_reg, tx_last_next;
    logic                tx_strobe_reg, tx_strobe_next;

    logic [TX_CNT_W-1:0] j, pb_sel, ridx_wide, len_m1, len_m2;
    logic [15:0]         rd_word;
    logic [7:0]          pay, out_byte;
    logic                crc_tail;

    assign pop = (state_reg == BK_IDLE) & ~q_stat.empty;

    assign j         = k_reg - TX_CNT_W'(3);
    assign pb_sel    = k_reg - TX_CNT_W'(2);
    assign ridx_wide = TX_CNT_W'(cmd_reg.start) + (j >> 1);
    assign rd_word   = hold_reg[ridx_wide[REG_IDX_W-1:0]];
    assign len_m1    = len_reg - TX_CNT_W'(1);
    assign len_m2    = len_reg - TX_CNT_W'(2);
    assign crc_tail  = (cmd_reg.kind != CMD_WRITE_ONE);

    // payload byte of the reply at position k
    always_comb
    begin
        pay = 8'h00;
        if (k_reg == '0)
        begin
            pay = slave_address;
        end
        else if (k_reg == TX_CNT_W'(1))
        begin
            unique case (cmd_reg.kind)
                CMD_READ:        pay = FC_READ_HOLD;
                CMD_WRITE_ONE:   pay = FC_WRITE_ONE;
                CMD_WRITE_MULTI: pay = FC_WRITE_MULTI;
                default:         pay = 8'h00;
            endcase
        end
        else if (cmd_reg.kind == CMD_READ)
        begin
            if (k_reg == TX_CNT_W'(2))
            begin
                pay = {3'b000, cmd_reg.qty, 1'b0};
            end
            else
            begin
                pay = j[0] ? rd_word[7:0] : rd_word[15:8];
            end
        end
        else
        begin
            pay = cmd_reg.pb[pb_sel[3:0]];
        end
    end

    always_comb
    begin
        priority if (crc_tail && k_reg == len_m2)
        begin
            out_byte = crc_reg[15:8];
        end
        else if (crc_tail && k_reg == len_m1)
        begin
            out_byte = crc_reg[7:0];
        end
        else
        begin
            out_byte = pay;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            k_reg         <= '0;
            len_reg       <= '0;
            crc_reg       <= CRC_INIT;
            tx_strobe_reg <= 1'b0;
            hold_reg      <= '{default: '0};
        end
        else
        begin
            state_reg     <= state_next;
            k_reg         <= k_next;
            len_reg       <= len_next;
            crc_reg       <= crc_next;
            tx_strobe_reg <= tx_strobe_next;
            hold_reg      <= hold_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg     <= cmd_next;
        tx_byte_reg <= tx_byte_next;
        tx_last_reg <= tx_last_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        k_next         = k_reg;
        len_next       = len_reg;
        crc_next       = crc_reg;
        hold_next      = hold_reg;
        tx_byte_next   = tx_byte_reg;
        tx_last_next   = 1'b0;
        tx_strobe_next = 1'b0;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (pop)
                begin
                    cmd_next = head;
                    k_next   = '0;
                    crc_next = CRC_INIT;
                    unique case (head.kind)
                        CMD_LOCAL:
                        begin
                            if (int'(head.lidx) < REG_COUNT)
                            begin
                                hold_next[REG_IDX_W'(head.lidx)] = head.lval;
                            end
                        end
                        CMD_READ:
                        begin
                            len_next   = TX_CNT_W'(READ_FIXED) + TX_CNT_W'({head.qty, 1'b0});
                            state_next = BK_EMIT;
                        end
                        CMD_WRITE_ONE:
                        begin
                            hold_next[REG_IDX_W'(head.start)] = {head.pb[2], head.pb[3]};
                            if (head.own)
                            begin
                                len_next   = TX_CNT_W'(ECHO_BYTES);
                                state_next = BK_EMIT;
                            end
                        end
                        CMD_WRITE_MULTI:
                        begin
                            hold_next[0] = {head.pb[5], head.pb[6]};
                            hold_next[1] = {head.pb[7], head.pb[8]};
                            hold_next[2] = {head.pb[9], head.pb[10]};
                            if (head.own)
                            begin
                                len_next   = TX_CNT_W'(ECHO_BYTES);
                                state_next = BK_EMIT;
                            end
                        end
                        default:
                        begin
                            state_next = BK_IDLE;
                        end
                    endcase
                end
            end
            BK_EMIT:
            begin
                tx_strobe_next = 1'b1;
                tx_byte_next   = out_byte;
                tx_last_next   = (k_reg == len_m1);
                // freeze the CRC once its own bytes go out
                if (k_reg < len_m2)
                begin
                    crc_next = crc_byte(crc_reg, pay);
                end
                k_next = k_reg + TX_CNT_W'(1);
                if (k_reg == len_m1)
                begin
                    state_next = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    assign tx_byte   = tx_byte_reg;
    assign tx_last   = tx_last_reg;
    assign tx_strobe = tx_strobe_reg;

endmodule
